// ----- rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to radix ASCII block
// Word and field widths, ASCII codes, the controller/datapath command and
// status bundles, and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);   // division step counter
    localparam int ND_W       = $clog2(WORD_WIDTH + 1); // digit count 0..WORD_WIDTH
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] LETTER_GAP = 8'h07;  // 'A' - '9' - 1

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // take a new input transfer
        logic push_sign;    // place '-' in the output register
        logic div_step;     // one shift-subtract step
        logic store_digit;  // save remainder as a digit, restart division
        logic emit;         // place the top stored digit in the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic neg;          // number is negative in signed mode
        logic step_last;    // final step of the current division
        logic quot_zero;    // quotient after the division is zero
        logic digits_one;   // one stored digit left
        logic out_free;     // output register can take a character
    } status_t;

    // Map a digit value 0..35 to '0'-'9', 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + {2'b00, d};
        if (c > CHAR_NINE) begin
            c = c + LETTER_GAP;
        end
        return c;
    endfunction

endpackage

// ----- rtl/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoa_ctrl: conversion sequencer
// Steps through load, optional sign, one division per digit, and the
// output of stored digits most significant first.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output itoa_pkg::cmd_t   cmd,
    input  itoa_pkg::status_t status
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!status.neg) begin
                    state_next = ST_DIV;
                end else if (status.out_free) begin
                    cmd.push_sign = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store_digit = 1'b1;
                state_next      = status.quot_zero ? ST_EMIT : ST_DIV;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.digits_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A digit string is only sent after the division of the last digit finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> $past(state_reg == ST_STORE || state_reg == ST_EMIT))
        else $error("itoa_ctrl: output phase entered without a stored digit");

    // A new transfer is taken only from idle, never mid conversion
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SIGN))
        else $error("itoa_ctrl: load did not start a conversion");

    // The sign goes out only before any digit is computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_sign |-> $past(cmd.load) || $past(state_reg == ST_SIGN))
        else $error("itoa_ctrl: sign issued outside the start of a conversion");

endmodule

// ----- rtl/itoa_dp.sv -----
// ----------------------------------------------------------------------------
// itoa_dp: conversion datapath
// Magnitude and radix registers, a restoring divider that retires one
// quotient bit per cycle, a digit stack and the output register.
// ----------------------------------------------------------------------------
module itoa_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  itoa_pkg::cmd_t                    cmd,
    output itoa_pkg::status_t                 status,
    input  logic                              s_cmd,
    input  logic [itoa_pkg::WORD_WIDTH-1:0]   s_value,
    input  logic [itoa_pkg::RADIX_W-1:0]      s_radix,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [itoa_pkg::CHAR_W-1:0]       m_character,
    output logic                              m_last
);
    import itoa_pkg::*;

    logic [WORD_WIDTH-1:0] mag_reg, mag_next;     // dividend, then quotient
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      step_reg;
    logic [ND_W-1:0]       nd_reg;
    logic [RADIX_W-1:0]    digit_mem [WORD_WIDTH];
    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     m_character_reg;
    logic                  m_last_reg;

    logic [RADIX_W:0]      rem_shift;
    logic [RADIX_W:0]      rem_diff;
    logic                  q_bit;
    logic [ND_W-1:0]       nd_top;

    // Divider step: shift in the next dividend bit and try to subtract
    assign rem_shift = {rem_reg, mag_reg[WORD_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, radix_reg};
    assign q_bit     = (rem_shift >= {1'b0, radix_reg});
    assign nd_top    = nd_reg - ND_W'(1);

    // Input capture with clamp and two's complement magnitude
    always_comb begin
        neg_next   = (s_cmd == CMD_SIGNED) && s_value[WORD_WIDTH-1];
        radix_next = s_radix;
        if (s_radix < RADIX_MIN) begin
            radix_next = RADIX_MIN;
        end else if (s_radix > RADIX_MAX) begin
            radix_next = RADIX_MAX;
        end
        if (cmd.load) begin
            mag_next = neg_next ? (~s_value + WORD_WIDTH'(1)) : s_value;
            rem_next = '0;
        end else if (cmd.div_step) begin
            mag_next = {mag_reg[WORD_WIDTH-2:0], q_bit};
            rem_next = q_bit ? rem_diff[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];
        end else if (cmd.store_digit) begin
            mag_next = mag_reg;
            rem_next = '0;
        end else begin
            mag_next = mag_reg;
            rem_next = rem_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        if (cmd.load) begin
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
        end
        if (cmd.store_digit) begin
            digit_mem[nd_reg[CNT_W-1:0]] <= rem_reg;
        end
    end

    // Step counter and digit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            nd_reg   <= '0;
        end else begin
            if (cmd.load || cmd.store_digit) begin
                step_reg <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                nd_reg <= '0;
            end else if (cmd.store_digit) begin
                nd_reg <= nd_reg + ND_W'(1);
            end else if (cmd.emit) begin
                nd_reg <= nd_top;
            end
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push_sign || cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_sign) begin
            m_character_reg <= CHAR_MINUS;
            m_last_reg      <= 1'b0;
        end else if (cmd.emit) begin
            m_character_reg <= digit_char(digit_mem[nd_top[CNT_W-1:0]]);
            m_last_reg      <= (nd_reg == ND_W'(1));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    assign status.neg        = neg_reg;
    assign status.step_last  = (step_reg == CNT_W'(WORD_WIDTH - 1));
    assign status.quot_zero  = (mag_reg == '0);
    assign status.digits_one = (nd_reg == ND_W'(1));
    assign status.out_free   = !m_valid_reg || m_ready;

    // Digit count never passes the word width
    assert property (@(posedge aclk) disable iff (!aresetn)
        nd_reg <= ND_W'(WORD_WIDTH))
        else $error("itoa_dp: digit count overflow");

    // A digit is only stored while the stack has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_digit |-> (nd_reg < ND_W'(WORD_WIDTH)))
        else $error("itoa_dp: digit stack full on store");

    // Emitting needs a stored digit and a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (nd_reg != '0) && status.out_free)
        else $error("itoa_dp: emit with empty stack or busy output");

    // The remainder stays below the radix once a division step is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.div_step) |-> (rem_reg < radix_reg))
        else $error("itoa_dp: remainder not below radix");

endmodule

// ----- rtl/integer_to_radix_ascii.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: integer to ASCII digits in radix 2..36
// Converts one 32-bit number (unsigned or two's complement) to its digit
// string, most significant first, with a leading '-' for negative numbers.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | s_valid s_ready s_cmd s_value s_radix | in
//   result  | m_valid m_ready m_character m_last    | out
//
// Each digit costs one shift-subtract division over every dividend bit
// plus a store step, and all digits are computed before the first goes out.
// One number is converted at a time; s_ready is high only when idle.
// The output register holds each character until its transfer; a stall
// there holds the sequencer but not the accepted input.
// Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [itoa_pkg::WORD_WIDTH-1:0]   s_value,
    input  logic [itoa_pkg::RADIX_W-1:0]      s_radix,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [itoa_pkg::CHAR_W-1:0]       m_character,
    output logic                              m_last
);
    import itoa_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Divider, digit stack and output register
    itoa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .s_radix     (s_radix),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// ----- test/tb_integer_to_radix_ascii.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_radix_ascii: self-checking bench for integer to radix ASCII
// Drives numbers in both modes and across the full radix field, predicts
// the digit string of every accepted number in a scoreboard, and compares
// each transferred character and its last flag in order. The sender idles
// in random bursts and the receiver stalls in random runs.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_ascii;

    import itoa_pkg::*;

    localparam int MAX_CYCLES  = 1_000_000;
    localparam int DRAIN_IDLE  = 60;
    localparam int RANDOM_NUMS = 87;

    localparam logic [CHAR_W-1:0] CHAR_LETTER_A = CHAR_NINE + LETTER_GAP + 8'd1;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } ascii_char_t;

    // Predicts the digit string of each number and checks characters in order
    class ascii_scoreboard;
        ascii_char_t pending_chars[$];
        int          failures;

        function new();
            failures = 0;
        endfunction

        // Work out the characters for one accepted number
        function void note_number(logic cmd, logic [WORD_WIDTH-1:0] value,
                                  logic [RADIX_W-1:0] radix);
            logic [WORD_WIDTH-1:0] mag;
            int unsigned           base;
            int unsigned           digit;
            logic [CHAR_W-1:0]     text[$];
            ascii_char_t           item;

            base = 32'(radix);
            if (base < RADIX_MIN) base = 32'(RADIX_MIN);
            if (base > RADIX_MAX) base = 32'(RADIX_MAX);
            mag = value;

            // Negative in signed mode: emit the sign, convert the magnitude
            if (cmd == CMD_SIGNED && mag[WORD_WIDTH-1]) begin
                text.push_back(CHAR_MINUS);
                mag = ~mag + 1'b1;
            end

            if (mag == '0) begin
                text.push_back(CHAR_ZERO);
            end else begin
                logic [CHAR_W-1:0] digits[$];
                while (mag != '0) begin
                    digit = mag % base;
                    if (digit < 10)
                        digits.push_front(CHAR_ZERO + CHAR_W'(digit));
                    else
                        digits.push_front(CHAR_LETTER_A + CHAR_W'(digit - 10));
                    mag = mag / base;
                end
                foreach (digits[i]) text.push_back(digits[i]);
            end

            foreach (text[i]) begin
                item.character = text[i];
                item.last      = (i == text.size() - 1);
                pending_chars.push_back(item);
            end
        endfunction

        // Compare one transferred character with the oldest prediction
        function void check_char(logic [CHAR_W-1:0] character, logic last);
            ascii_char_t want;
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h (last %b) with nothing pending",
                       character, last);
                failures++;
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character) begin
                $error("m_character mismatch: expected %h, got %h",
                       want.character, character);
                failures++;
            end
            if (last !== want.last) begin
                $error("m_last mismatch: expected %b, got %b", want.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic                   s_cmd       = CMD_UNSIGNED;
    logic [WORD_WIDTH-1:0]  s_value     = '0;
    logic [RADIX_W-1:0]     s_radix     = RADIX_MIN;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [CHAR_W-1:0]      m_character;
    logic                   m_last;

    ascii_scoreboard sb;
    int              burst_left = 0;
    int              cycle_count = 0;
    int              ready_run = 0;
    logic            ready_level = 1'b0;

    integer_to_radix_ascii u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .s_radix     (s_radix),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: long ready runs and short random stalls in random order
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            ready_level = ($urandom_range(0, 2) != 0);
            ready_run   = ready_level ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        ready_run--;
        m_ready <= ready_level;
    end

    // Check every character transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_character, m_last);
        end
    end

    // Present one number, hold it until its transfer, then maybe idle
    task automatic send_number(input logic cmd, input logic [WORD_WIDTH-1:0] value,
                               input logic [RADIX_W-1:0] radix);
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= value;
        s_radix <= radix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_number(cmd, value, radix);

        // Drop valid between bursts
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(0, 5);
        end
    endtask

    initial begin
        logic                  cmd;
        logic [WORD_WIDTH-1:0] value;
        logic [RADIX_W-1:0]    radix;
        int unsigned           pick;

        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero in both modes
        send_number(CMD_UNSIGNED, 32'h0000_0000, 6'd10);
        send_number(CMD_SIGNED,   32'h0000_0000, 6'd10);
        // All ones: longest unsigned string, and minus one
        send_number(CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd2);
        send_number(CMD_UNSIGNED, 32'hFFFF_FFFF, 6'd36);
        send_number(CMD_SIGNED,   32'hFFFF_FFFF, 6'd10);
        // Sign boundary values, with the longest string overall
        send_number(CMD_SIGNED,   32'h8000_0000, 6'd10);
        send_number(CMD_SIGNED,   32'h8000_0000, 6'd2);
        send_number(CMD_SIGNED,   32'h8000_0000, 6'd16);
        send_number(CMD_UNSIGNED, 32'h8000_0000, 6'd10);
        send_number(CMD_SIGNED,   32'h7FFF_FFFF, 6'd10);
        // Radix below two and above thirty-six
        send_number(CMD_UNSIGNED, 32'd5,         6'd0);
        send_number(CMD_UNSIGNED, 32'd255,       6'd1);
        send_number(CMD_UNSIGNED, 32'd1295,      6'd37);
        send_number(CMD_UNSIGNED, 32'd35,        6'd63);
        send_number(CMD_SIGNED,   32'hFFFF_FFDD, 6'd63);
        // Digit and letter boundaries, then mixed values in several radixes
        send_number(CMD_UNSIGNED, 32'd36,        6'd36);
        send_number(CMD_UNSIGNED, 32'd9,         6'd10);
        send_number(CMD_UNSIGNED, 32'd10,        6'd10);
        send_number(CMD_UNSIGNED, 32'd10,        6'd11);
        send_number(CMD_UNSIGNED, 32'hDEAD_BEEF, 6'd16);
        send_number(CMD_SIGNED,   32'h1234_5670, 6'd8);
        send_number(CMD_UNSIGNED, 32'h5555_AAAA, 6'd3);
        send_number(CMD_SIGNED,   32'hC000_0001, 6'd7);

        // Random numbers, mostly in-range radixes
        repeat (RANDOM_NUMS) begin
            cmd  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                value = $urandom;
            else if (pick < 60)
                value = $urandom_range(0, 1400);
            else if (pick < 75) begin
                case ($urandom_range(0, 3))
                    0: value = 32'h8000_0000 + $urandom_range(0, 3);
                    1: value = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    2: value = 32'h7FFF_FFFF - $urandom_range(0, 3);
                    default: value = $urandom_range(0, 3);
                endcase
            end else
                value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 99) < 85)
                radix = RADIX_W'($urandom_range(2, 36));
            else
                radix = RADIX_W'($urandom_range(0, 63));
            send_number(cmd, value, radix);
        end
        s_valid <= 1'b0;

        // Drain, then look for stray characters
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_IDLE) @(posedge aclk);

        if (sb.pending() != 0) begin
            $error("%0d characters never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
